[src/tlaik_pkg.sv]
package tlaik_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int COORD_BITS   = 7;
    localparam int ARC_ENTRIES  = 24;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OFF_W     = 11;
    localparam int POS_W     = 10;

    // squared radius, link length and sqrt datapath
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int LEN_W  = COORD_BITS + 16;
    localparam int RAD_W  = 2 * COORD_BITS + 32;
    localparam int ROOT_W = LEN_W;
    localparam int REM_W  = ROOT_W + 3;

    // law of cosines numerators and divider
    localparam int NUM_RAW = (2 * COORD_BITS + 17 > 33) ? 2 * COORD_BITS + 17 : 33;
    localparam int N_W     = NUM_RAW + 1;
    localparam int D1_W    = LEN_W + 16;
    localparam int DIV_W   = D1_W + 1;
    localparam int CMP_W   = N_W + D1_W;
    localparam int Q_W     = 17;

    // acos operand sqrt, 17 digit pairs of a 34 bit radicand
    localparam int ACOS_STEPS = 17;
    localparam int ARG_W      = 34;

    // cordic
    localparam int CW   = (COORD_BITS + 18 > 27) ? COORD_BITS + 18 : 27;
    localparam int ZW   = 26;
    localparam int SH_W = $clog2(ARC_ENTRIES);

    // angle to code
    localparam int TH_W       = ZW + 1;
    localparam int P_W        = TH_W + 17;
    localparam int ACC_W      = P_W + 1;
    localparam int CODE_SHIFT = 28;
    localparam int OFF_SHIFT  = 27;

    localparam logic signed [ZW-1:0]   DEG_90  = ZW'(90 * 65536);
    localparam logic signed [TH_W-1:0] DEG_270 = TH_W'(270 * 65536);
    localparam logic [ARG_W-1:0]       ARG_ONE = ARG_W'(64'd1 << 32);
    localparam logic [POS_W-1:0]       POS_MAX = '1;

    localparam logic [CFG_W-1:0] RST_FIRST_LINK  = 16'd2496;
    localparam logic [CFG_W-1:0] RST_SECOND_LINK = 16'd2691;
    localparam logic [CFG_W-1:0] RST_GAIN        = 16'd12584;
    localparam logic [OFF_W-1:0] RST_OFFSET      = 11'd471;
    localparam logic [POS_W-1:0] RST_WRIST       = 10'd777;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_LINK  = 3'd0,
        CFG_SECOND_LINK = 3'd1,
        CFG_GAIN        = 3'd2,
        CFG_OFFSET      = 3'd3,
        CFG_WRIST       = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [DIV_W-1:0] r;
        logic [DIV_W-1:0] d;
        logic [Q_W-1:0]   q;
    } t_div;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cvec;

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [ZW-1:0] arc_at(input logic [SH_W-1:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:    a = ZW'(2949120);
            5'd1:    a = ZW'(1740967);
            5'd2:    a = ZW'(919879);
            5'd3:    a = ZW'(466945);
            5'd4:    a = ZW'(234379);
            5'd5:    a = ZW'(117304);
            5'd6:    a = ZW'(58666);
            5'd7:    a = ZW'(29335);
            5'd8:    a = ZW'(14668);
            5'd9:    a = ZW'(7334);
            5'd10:   a = ZW'(3667);
            5'd11:   a = ZW'(1833);
            5'd12:   a = ZW'(917);
            5'd13:   a = ZW'(458);
            5'd14:   a = ZW'(229);
            5'd15:   a = ZW'(115);
            5'd16:   a = ZW'(57);
            5'd17:   a = ZW'(29);
            5'd18:   a = ZW'(14);
            5'd19:   a = ZW'(7);
            5'd20:   a = ZW'(4);
            5'd21:   a = ZW'(2);
            5'd22:   a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    // quarter turn so the vector starts in the right half plane
    function automatic t_cvec cordic_pre(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
        t_cvec v;
        v.x = x;
        v.y = y;
        v.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = DEG_90;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -DEG_90;
            end
        end
        return v;
    endfunction

endpackage

[src/tlaik_sqrt_cell.sv]
module tlaik_sqrt_cell
    import tlaik_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sqrt i_data,
    output t_sqrt o_data
);

    t_sqrt             r_data;
    t_sqrt             n_data;
    logic [REM_W-1:0]  rem2;
    logic [REM_W-1:0]  trial;

    always_comb begin
        rem2       = {i_data.rem[REM_W-3:0], i_data.rad[RAD_W-1 -: 2]};
        trial      = {1'b0, i_data.root, 2'b01};
        n_data.rad = {i_data.rad[RAD_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            n_data.rem  = rem2 - trial;
            n_data.root = {i_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = rem2;
            n_data.root = {i_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[src/tlaik_div_cell.sv]
module tlaik_div_cell
    import tlaik_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_data,
    output t_div o_data
);

    t_div             r_data;
    t_div             n_data;
    logic [DIV_W-1:0] diff;
    logic             bit_q;

    always_comb begin
        bit_q    = (i_data.r >= i_data.d);
        diff     = i_data.r - i_data.d;
        n_data.d = i_data.d;
        n_data.q = {i_data.q[Q_W-2:0], bit_q};
        // remainder stays below d, so the doubling cannot overflow
        if (bit_q) begin
            n_data.r = {diff[DIV_W-2:0], 1'b0};
        end else begin
            n_data.r = {i_data.r[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[src/tlaik_cordic_cell.sv]
module tlaik_cordic_cell
    import tlaik_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SH_W-1:0] i_shift,
    input  t_cvec           i_data,
    output t_cvec           o_data
);

    t_cvec                r_data;
    t_cvec                n_data;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] arc;

    always_comb begin
        dx  = i_data.y >>> i_shift;
        dy  = i_data.x >>> i_shift;
        arc = arc_at(i_shift);
        if (i_data.y > 0) begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + arc;
        end else begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - arc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[src/two_link_arm_inverse_kinematics.sv]
// two-link planar arm inverse kinematics
// input channel: i_in_valid / o_in_ready carry one target beat (x, y in cm).
// output channel: o_out_valid / i_out_ready carry one result beat per target:
//   base and shoulder servo codes, the wrist code, unreachable and clamped flags.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the edge;
//   write only while no target is in flight.
// path: from accept to o_out_valid a target passes stage 1 (radius squared),
//   the length square root row (one root bit per cell), the denominator
//   multiply and reach check stages, the divider row (one quotient bit per cell),
//   the acos radicand stage, the acos root row, the acos pre-rotation stage, the
//   acos cordic row (one micro-rotation per cell), and the angle difference, gain
//   multiply, code clamp and output register stages.
// throughput: one target per cycle while the skid register is empty; every row
//   of cells advances together.
// stall: a stalled result is held in the output register while the pipeline
//   drains one more beat into a skid register; o_in_ready drops only while the
//   skid register is full.
// reset: the pipeline and output empty, the registers take their reset values.
module two_link_arm_inverse_kinematics
    import tlaik_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_target_x,
    input  logic signed [COORD_BITS-1:0] i_target_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [POS_W-1:0]             o_base_position,
    output logic [POS_W-1:0]             o_shoulder_position,
    output logic [POS_W-1:0]             o_wrist_out,
    output logic                         o_unreachable,
    output logic                         o_clamped
);

    localparam int ST_PHI = CORDIC_STEPS + 2;
    localparam int ST_D1  = LEN_W + 2;
    localparam int ST_CK  = ST_D1 + 1;
    localparam int ST_SQ  = ST_CK + Q_W + 1;
    localparam int ST_AC  = ST_SQ + ACOS_STEPS + 1;
    localparam int ST_TH  = ST_AC + CORDIC_STEPS + 1;
    localparam int ST_MU  = ST_TH + 1;
    localparam int LAST   = ST_MU + 1;

    typedef struct packed {
        logic                   bad;
        logic [SQ_W-1:0]        sq;
        t_cvec                  phi_in;
        t_sqrt                  len_in;
        logic signed [ZW-1:0]   phi;
        logic signed [N_W-1:0]  n1;
        logic signed [N_W-1:0]  n2;
        logic [D1_W-1:0]        d1;
        logic                   neg1;
        logic                   neg2;
        t_div                   div1_in;
        t_div                   div2_in;
        logic [Q_W-1:0]         q1;
        logic [Q_W-1:0]         q2;
        t_sqrt                  sq1_in;
        t_sqrt                  sq2_in;
        t_cvec                  ac1_in;
        t_cvec                  ac2_in;
        logic signed [TH_W-1:0] th0;
        logic signed [TH_W-1:0] th1;
        logic signed [P_W-1:0]  p0;
        logic signed [P_W-1:0]  p1;
        logic [POS_W-1:0]       base;
        logic [POS_W-1:0]       shoulder;
        logic                   clip;
    } t_band;

    typedef struct packed {
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] shoulder;
        logic [POS_W-1:0] wrist;
        logic             unreach;
        logic             clip;
    } t_result;

    typedef struct packed {
        logic [POS_W-1:0] code;
        logic             clip;
    } t_code;

    function automatic t_code to_code(input logic signed [P_W-1:0] p,
                                      input logic [OFF_W-1:0] off);
        logic signed [ACC_W-1:0] offs;
        logic signed [ACC_W-1:0] acc;
        logic [ACC_W-1:0]        mag;
        logic [ACC_W-1:0]        hi;
        t_code                   c;
        offs = $signed({{(ACC_W-OFF_W-OFF_SHIFT){1'b0}}, off, {OFF_SHIFT{1'b0}}});
        acc  = ACC_W'(p) + offs;
        mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        hi   = mag >> CODE_SHIFT;
        // truncation toward zero: small negative sums give code zero, no clip
        if (acc[ACC_W-1] && hi != '0) begin
            c.code = '0;
            c.clip = 1'b1;
        end else if (!acc[ACC_W-1] && hi > ACC_W'(POS_MAX)) begin
            c.code = POS_MAX;
            c.clip = 1'b1;
        end else begin
            c.code = hi[POS_W-1:0];
            c.clip = 1'b0;
        end
        return c;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_first_link_length;
    logic [CFG_W-1:0] r_second_link_length;
    logic [CFG_W-1:0] r_degree_gain;
    logic [OFF_W-1:0] r_position_offset;
    logic [POS_W-1:0] r_wrist_position;
    logic [31:0]      r_l1_sq;
    logic [31:0]      r_l2_sq;
    logic [32:0]      r_den2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_link_length  <= RST_FIRST_LINK;
            r_second_link_length <= RST_SECOND_LINK;
            r_degree_gain        <= RST_GAIN;
            r_position_offset    <= RST_OFFSET;
            r_wrist_position     <= RST_WRIST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_LINK:  r_first_link_length  <= i_cfg_data;
                CFG_SECOND_LINK: r_second_link_length <= i_cfg_data;
                CFG_GAIN:        r_degree_gain        <= i_cfg_data;
                CFG_OFFSET:      r_position_offset    <= i_cfg_data[OFF_W-1:0];
                CFG_WRIST:       r_wrist_position     <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // link terms follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_l1_sq <= 32'(r_first_link_length) * 32'(r_first_link_length);
        r_l2_sq <= 32'(r_second_link_length) * 32'(r_second_link_length);
        r_den2  <= {33'(r_first_link_length) * 33'(r_second_link_length)} << 1;
    end

    // pipeline control and output skid
    logic              en;
    logic [LAST:1]     r_v;
    t_band             r_band [1:LAST];
    t_result           r_out;
    t_result           r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    t_result           last_res;
    logic              take;

    assign en   = ~r_skid_valid;
    assign take = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAST-1:1], i_in_valid};
        end
    end

    // stage 1: radius squared and the start of the target angle
    t_band                        n_b1;
    logic [COORD_BITS-1:0]        ax;
    logic [COORD_BITS-1:0]        ay;
    logic signed [CW-1:0]         xs;
    logic signed [CW-1:0]         ys;

    always_comb begin
        ax   = i_target_x[COORD_BITS-1] ? COORD_BITS'(-i_target_x) : COORD_BITS'(i_target_x);
        ay   = i_target_y[COORD_BITS-1] ? COORD_BITS'(-i_target_y) : COORD_BITS'(i_target_y);
        xs   = $signed({{(CW-COORD_BITS-16){i_target_x[COORD_BITS-1]}}, i_target_x, 16'b0});
        ys   = $signed({{(CW-COORD_BITS-16){i_target_y[COORD_BITS-1]}}, i_target_y, 16'b0});
        n_b1 = '0;
        n_b1.sq  = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
        n_b1.bad = (i_target_x == '0 && i_target_y == '0) ||
                   r_first_link_length == '0 || r_second_link_length == '0;
        n_b1.len_in.rad  = {n_b1.sq, 32'b0};
        n_b1.len_in.rem  = '0;
        n_b1.len_in.root = '0;
        n_b1.phi_in      = cordic_pre(xs, ys);
    end

    // cell rows
    t_cvec w_phi [CORDIC_STEPS+1];
    t_sqrt w_len [LEN_W+1];
    t_div  w_dv1 [Q_W+1];
    t_div  w_dv2 [Q_W+1];
    t_sqrt w_sr1 [ACOS_STEPS+1];
    t_sqrt w_sr2 [ACOS_STEPS+1];
    t_cvec w_ac1 [CORDIC_STEPS+1];
    t_cvec w_ac2 [CORDIC_STEPS+1];

    assign w_phi[0] = r_band[1].phi_in;
    assign w_len[0] = r_band[1].len_in;
    assign w_dv1[0] = r_band[ST_CK].div1_in;
    assign w_dv2[0] = r_band[ST_CK].div2_in;
    assign w_sr1[0] = r_band[ST_SQ].sq1_in;
    assign w_sr2[0] = r_band[ST_SQ].sq2_in;
    assign w_ac1[0] = r_band[ST_AC].ac1_in;
    assign w_ac2[0] = r_band[ST_AC].ac2_in;

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        tlaik_cordic_cell u_phi (
            .i_clk, .i_en(en), .i_shift(SH_W'(j)), .i_data(w_phi[j]), .o_data(w_phi[j+1])
        );
        tlaik_cordic_cell u_ac1 (
            .i_clk, .i_en(en), .i_shift(SH_W'(j)), .i_data(w_ac1[j]), .o_data(w_ac1[j+1])
        );
        tlaik_cordic_cell u_ac2 (
            .i_clk, .i_en(en), .i_shift(SH_W'(j)), .i_data(w_ac2[j]), .o_data(w_ac2[j+1])
        );
    end

    for (genvar j = 0; j < LEN_W; j++) begin : g_len
        tlaik_sqrt_cell u_cell (.i_clk, .i_en(en), .i_data(w_len[j]), .o_data(w_len[j+1]));
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        tlaik_div_cell u_dv1 (.i_clk, .i_en(en), .i_data(w_dv1[j]), .o_data(w_dv1[j+1]));
        tlaik_div_cell u_dv2 (.i_clk, .i_en(en), .i_data(w_dv2[j]), .o_data(w_dv2[j+1]));
    end

    for (genvar j = 0; j < ACOS_STEPS; j++) begin : g_acos_root
        tlaik_sqrt_cell u_sr1 (.i_clk, .i_en(en), .i_data(w_sr1[j]), .o_data(w_sr1[j+1]));
        tlaik_sqrt_cell u_sr2 (.i_clk, .i_en(en), .i_data(w_sr2[j]), .o_data(w_sr2[j+1]));
    end

    // numerators and base denominator
    logic signed [N_W-1:0] n_n1;
    logic signed [N_W-1:0] n_n2;
    logic [D1_W-1:0]       n_d1;

    always_comb begin
        n_n1 = N_W'(r_l1_sq) + N_W'({r_band[ST_D1-1].sq, 16'b0}) - N_W'(r_l2_sq);
        n_n2 = N_W'(r_l1_sq) + N_W'(r_l2_sq) - N_W'({r_band[ST_D1-1].sq, 16'b0});
        n_d1 = D1_W'(r_first_link_length) * D1_W'(w_len[LEN_W].root);
    end

    // reach check and divider setup
    logic [N_W-1:0] m1;
    logic [N_W-1:0] m2;
    logic           over1;
    logic           over2;
    t_div           n_dv1;
    t_div           n_dv2;

    always_comb begin
        m1    = r_band[ST_CK-1].n1[N_W-1] ? N_W'(-r_band[ST_CK-1].n1) : N_W'(r_band[ST_CK-1].n1);
        m2    = r_band[ST_CK-1].n2[N_W-1] ? N_W'(-r_band[ST_CK-1].n2) : N_W'(r_band[ST_CK-1].n2);
        over1 = CMP_W'({m1, 7'b0}) > CMP_W'(r_band[ST_CK-1].d1);
        over2 = CMP_W'(m2) > CMP_W'(r_den2);
        n_dv1.r = DIV_W'({m1, 7'b0});
        n_dv1.d = DIV_W'(r_band[ST_CK-1].d1);
        n_dv1.q = '0;
        n_dv2.r = DIV_W'(m2);
        n_dv2.d = DIV_W'(r_den2);
        n_dv2.q = '0;
    end

    // acos: s = sqrt(1 - t^2) in Q16
    logic [ARG_W-1:0] arg1;
    logic [ARG_W-1:0] arg2;
    t_sqrt            n_sr1;
    t_sqrt            n_sr2;

    always_comb begin
        arg1 = ARG_ONE - ARG_W'(w_dv1[Q_W].q) * ARG_W'(w_dv1[Q_W].q);
        arg2 = ARG_ONE - ARG_W'(w_dv2[Q_W].q) * ARG_W'(w_dv2[Q_W].q);
        n_sr1.rad  = {arg1, {(RAD_W-ARG_W){1'b0}}};
        n_sr1.rem  = '0;
        n_sr1.root = '0;
        n_sr2.rad  = {arg2, {(RAD_W-ARG_W){1'b0}}};
        n_sr2.rem  = '0;
        n_sr2.root = '0;
    end

    // acos vectors (t, s) scaled by 256
    logic signed [CW-1:0] tx1;
    logic signed [CW-1:0] tx2;
    logic signed [CW-1:0] sy1;
    logic signed [CW-1:0] sy2;

    always_comb begin
        tx1 = $signed({{(CW-Q_W-8){1'b0}}, r_band[ST_AC-1].q1, 8'b0});
        tx2 = $signed({{(CW-Q_W-8){1'b0}}, r_band[ST_AC-1].q2, 8'b0});
        if (r_band[ST_AC-1].neg1) begin
            tx1 = -tx1;
        end
        if (r_band[ST_AC-1].neg2) begin
            tx2 = -tx2;
        end
        sy1 = $signed({{(CW-Q_W-8){1'b0}}, w_sr1[ACOS_STEPS].root[Q_W-1:0], 8'b0});
        sy2 = $signed({{(CW-Q_W-8){1'b0}}, w_sr2[ACOS_STEPS].root[Q_W-1:0], 8'b0});
    end

    // codes
    t_code c0;
    t_code c1;

    always_comb begin
        c0 = to_code(r_band[LAST-1].p0, r_position_offset);
        c1 = to_code(r_band[LAST-1].p1, r_position_offset);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_band[1] <= n_b1;
            for (int k = 2; k <= LAST; k++) begin
                r_band[k] <= r_band[k-1];
            end
            r_band[ST_PHI].phi    <= w_phi[CORDIC_STEPS].z;
            r_band[ST_D1].n1      <= n_n1;
            r_band[ST_D1].n2      <= n_n2;
            r_band[ST_D1].d1      <= n_d1;
            r_band[ST_CK].neg1    <= r_band[ST_CK-1].n1[N_W-1];
            r_band[ST_CK].neg2    <= r_band[ST_CK-1].n2[N_W-1];
            r_band[ST_CK].bad     <= r_band[ST_CK-1].bad | over1 | over2;
            r_band[ST_CK].div1_in <= n_dv1;
            r_band[ST_CK].div2_in <= n_dv2;
            r_band[ST_SQ].q1      <= w_dv1[Q_W].q;
            r_band[ST_SQ].q2      <= w_dv2[Q_W].q;
            r_band[ST_SQ].sq1_in  <= n_sr1;
            r_band[ST_SQ].sq2_in  <= n_sr2;
            r_band[ST_AC].ac1_in  <= cordic_pre(tx1, sy1);
            r_band[ST_AC].ac2_in  <= cordic_pre(tx2, sy2);
            r_band[ST_TH].th0     <= TH_W'(r_band[ST_TH-1].phi) - TH_W'(w_ac1[CORDIC_STEPS].z);
            r_band[ST_TH].th1     <= DEG_270 - TH_W'(w_ac2[CORDIC_STEPS].z);
            r_band[ST_MU].p0      <= P_W'($signed({1'b0, r_degree_gain})) *
                                     P_W'(r_band[ST_MU-1].th0);
            r_band[ST_MU].p1      <= P_W'($signed({1'b0, r_degree_gain})) *
                                     P_W'(r_band[ST_MU-1].th1);
            r_band[LAST].base     <= r_band[LAST-1].bad ? '0 : c0.code;
            r_band[LAST].shoulder <= r_band[LAST-1].bad ? '0 : c1.code;
            r_band[LAST].clip     <= ~r_band[LAST-1].bad & (c0.clip | c1.clip);
        end
    end

    always_comb begin
        last_res.base     = r_band[LAST].base;
        last_res.shoulder = r_band[LAST].shoulder;
        last_res.wrist    = r_wrist_position;
        last_res.unreach  = r_band[LAST].bad;
        last_res.clip     = r_band[LAST].clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_v[LAST]) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (r_v[LAST]) begin
            if (!r_out_valid || take) begin
                r_out <= last_res;
            end else begin
                r_skid <= last_res;
            end
        end
    end

    assign o_in_ready          = en;
    assign o_out_valid         = r_out_valid;
    assign o_base_position     = r_out.base;
    assign o_shoulder_position = r_out.shoulder;
    assign o_wrist_out         = r_out.wrist;
    assign o_unreachable       = r_out.unreach;
    assign o_clamped           = r_out.clip;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full with output register empty");

    a_last_beat_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LAST] && en) |=> r_out_valid)
        else $error("finished beat left the pipeline without reaching the output");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unreachable) |->
        (o_base_position == '0 && o_shoulder_position == '0 && !o_clamped))
        else $error("unreachable result carries positions or clamp");

    a_clamp_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clamped) |->
        (o_base_position == '0 || o_base_position == POS_MAX ||
         o_shoulder_position == '0 || o_shoulder_position == POS_MAX))
        else $error("clamp flag without a position on a rail");
`endif

endmodule
